// File: hdl/cptri_pkg.sv
// Shared constants and types for the closest-point-on-triangle pipeline.
package cptri_pkg;

    // Fraction bits of the clamped triangle parameters (unsigned Q1.32).
    localparam int PFRAC = 32;
    // Quotient bits produced by the divider: one guard bit below PFRAC for rounding.
    localparam int QBITS = PFRAC + 1;
    // Width of one multiplier digit in the pipelined multipliers.
    localparam int CHUNK = 16;

    // How a clamped quotient resolves once its operands are known.
    typedef enum logic [1:0] {
        QC_DIV  = 2'd0,
        QC_ZERO = 2'd1,
        QC_ONE  = 2'd2
    } qclass_t;

    // Which divider lanes feed the parameters of the chosen region.
    typedef struct packed {
        logic use0;   // s' comes from lane 0
        logic use1;   // t' comes from lane 1
        logic comp;   // t' is one minus s'
    } sel_t;

    // Control that rides alongside the divider.
    typedef struct packed {
        sel_t    sel;
        qclass_t cls0;
        qclass_t cls1;
        logic    ok;
    } ctl_t;

endpackage

// File: hdl/cptri_dly.sv
// Enabled shift register that keeps side data aligned with the pipeline.
module cptri_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] pipe_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[DEPTH-1];

endmodule

// File: hdl/cptri_mul.sv
// Pipelined signed multiplier that consumes one 16-bit digit of y per stage.
module cptri_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AW-1:0]    x,
    input  logic signed [BW-1:0]    y,
    output logic signed [AW+BW-1:0] p
);

    localparam int CW = cptri_pkg::CHUNK;
    localparam int NC = (BW + CW - 1) / CW;
    localparam int YW = NC * CW;
    localparam int PW = AW + BW;

    logic signed [AW-1:0] x_reg   [NC-1];
    logic signed [YW-1:0] y_reg   [NC-1];
    logic signed [PW-1:0] acc_reg [NC];

    for (genvar j = 0; j < NC; j++)
    begin : g_stage
        logic signed [AW-1:0]    xs;
        logic signed [YW-1:0]    ys;
        logic signed [PW-1:0]    acc_in;
        logic signed [CW:0]      ch;
        logic signed [AW+CW:0]   pp;
        logic signed [PW-1:0]    pp_ext;

        if (j == 0)
        begin : g_first
            assign xs     = x;
            assign ys     = YW'(y);
            assign acc_in = '0;
        end
        else
        begin : g_rest
            assign xs     = x_reg[j-1];
            assign ys     = y_reg[j-1];
            assign acc_in = acc_reg[j-1];
        end

        // Lower digits are unsigned; the top digit carries the sign of y.
        assign ch     = {((j == NC - 1) ? ys[YW-1] : 1'b0), ys[j*CW +: CW]};
        assign pp     = xs * ch;
        assign pp_ext = PW'(pp);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[j] <= acc_in + (pp_ext <<< (j * CW));
            end
        end

        if (j < NC - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[j] <= xs;
                    y_reg[j] <= ys;
                end
            end
        end
    end

    assign p = acc_reg[NC-1];

endmodule

// File: hdl/cptri_div.sv
// Pipelined restoring divider that yields one quotient bit per stage.
module cptri_div #(
    parameter int NB = 64
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [NB-1:0]                num,
    input  logic [NB-1:0]                den,
    output logic [cptri_pkg::QBITS-1:0]  q
);

    localparam int QB = cptri_pkg::QBITS;

    logic [NB-1:0] r_reg [QB];
    logic [NB-1:0] d_reg [QB-1];
    logic [QB-1:0] q_reg [QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [NB-1:0] rin;
        logic [NB-1:0] din;
        logic [QB-1:0] qin;
        logic [NB:0]   two;
        logic [NB:0]   diff;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rin = num;
            assign din = den;
            assign qin = '0;
        end
        else
        begin : g_rest
            assign rin = r_reg[k-1];
            assign din = d_reg[k-1];
            assign qin = q_reg[k-1];
        end

        assign two  = {rin, 1'b0};
        assign ge   = (two >= {1'b0, din});
        assign diff = two - {1'b0, din};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k] <= ge ? diff[NB-1:0] : two[NB-1:0];
                q_reg[k] <= {qin[QB-2:0], ge};
            end
        end

        if (k < QB - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_reg[k] <= din;
                end
            end
        end
    end

    assign q = q_reg[QB-1];

endmodule

// File: hdl/closest_point_on_triangle_core.sv
// Top level of the closest-point-on-triangle pipeline.
//
// Channel  Dir  Handshake              Payload
// s_*      in   s_tvalid / s_tready    s_tdata: P, A, B, C coordinates (12 x COORD_WIDTH)
// m_*      out  m_tvalid / m_tready    m_tdata: closest x, y, z; m_tuser: degenerate flag
//
// The block accepts one transaction per clock unless the output is stalled,
// and keeps no state between items.
// The 33 quotient bits of the two parallel restoring dividers set most of the
// pipeline depth.
// Reset clears only the valid bits; data registers are not reset.
// A stall on the output freezes every stage at once, so no item is lost or repeated;
// s_tready is high whenever the output register is empty or is being drained.
module closest_point_on_triangle_core #(
    parameter int COORD_WIDTH = 32,
    localparam int IN_DW  = ((12 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // From bit 0 up: point_x, point_y, point_z, vertex_a_x, vertex_a_y, vertex_a_z,
    // vertex_b_x, vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, zero fill.
    input  logic [IN_DW-1:0]  s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // From bit 0 up: closest_x, closest_y, closest_z, zero fill.
    output logic [OUT_DW-1:0] m_tdata,
    // degenerate
    output logic              m_tuser
);

    localparam int W   = COORD_WIDTH;
    localparam int PF  = cptri_pkg::PFRAC;
    localparam int QB  = cptri_pkg::QBITS;
    localparam int CW  = cptri_pkg::CHUNK;
    // Edge and offset vectors, single products and dot products.
    localparam int EW  = W + 1;
    localparam int PW1 = 2 * EW;
    localparam int DW  = PW1 + 2;
    // Second-order terms (det, s, t) and the operands of the quotients.
    localparam int PW2 = 2 * DW;
    localparam int XW  = PW2 + 1;
    localparam int NB  = XW - 1;
    // Final interpolation products and their rounded sum.
    localparam int YB  = QB + 1;
    localparam int PW3 = EW + YB;
    localparam int RW  = PW3 + 1 - PF;
    // Stage timing.
    localparam int L1  = (EW + CW - 1) / CW;
    localparam int L2  = (DW + CW - 1) / CW;
    localparam int L3  = (YB + CW - 1) / CW;
    localparam int T1  = 1;
    localparam int T2  = T1 + L1 + 1;
    localparam int T3  = T2 + L2 + 1;
    localparam int T4  = T3 + 1;
    localparam int T5  = T4 + 1;
    localparam int T6  = T5 + QB + 1;
    localparam int T7  = T6 + L3 + 1;
    localparam int LAT = T7 + 1;
    localparam int CTW = $bits(cptri_pkg::ctl_t);

    // Global advance: every stage moves together unless the output is held.
    logic en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];
    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage T1: edge vectors E0 = B - A, E1 = C - A and offset V = A - P.
    // ------------------------------------------------------------------
    logic signed [EW-1:0] e0_reg [3];
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] v0_reg [3];
    logic signed [W-1:0]  va_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e0_reg[i] <= EW'($signed(s_tdata[(6+i)*W +: W]))
                           - EW'($signed(s_tdata[(3+i)*W +: W]));
                e1_reg[i] <= EW'($signed(s_tdata[(9+i)*W +: W]))
                           - EW'($signed(s_tdata[(3+i)*W +: W]));
                v0_reg[i] <= EW'($signed(s_tdata[(3+i)*W +: W]))
                           - EW'($signed(s_tdata[i*W +: W]));
                va_reg[i] <= $signed(s_tdata[(3+i)*W +: W]);
            end
        end
    end

    // ------------------------------------------------------------------
    // First multiplier bank: the fifteen component products of the dots.
    // ------------------------------------------------------------------
    logic signed [PW1-1:0] pa [3];
    logic signed [PW1-1:0] pb [3];
    logic signed [PW1-1:0] pc [3];
    logic signed [PW1-1:0] pd [3];
    logic signed [PW1-1:0] pe [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_dot
        cptri_mul #(.AW(EW), .BW(EW)) u_ma (
            .clk(clk), .en(en), .x(e0_reg[i]), .y(e0_reg[i]), .p(pa[i]));
        cptri_mul #(.AW(EW), .BW(EW)) u_mb (
            .clk(clk), .en(en), .x(e0_reg[i]), .y(e1_reg[i]), .p(pb[i]));
        cptri_mul #(.AW(EW), .BW(EW)) u_mc (
            .clk(clk), .en(en), .x(e1_reg[i]), .y(e1_reg[i]), .p(pc[i]));
        cptri_mul #(.AW(EW), .BW(EW)) u_md (
            .clk(clk), .en(en), .x(e0_reg[i]), .y(v0_reg[i]), .p(pd[i]));
        cptri_mul #(.AW(EW), .BW(EW)) u_me (
            .clk(clk), .en(en), .x(e1_reg[i]), .y(v0_reg[i]), .p(pe[i]));
    end

    // ------------------------------------------------------------------
    // Stage T2: dot products a = E0.E0, b = E0.E1, c = E1.E1, d = E0.V, e = E1.V.
    // ------------------------------------------------------------------
    logic signed [DW-1:0] a_reg, b_reg, c_reg, d_reg, e_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= DW'(pa[0]) + DW'(pa[1]) + DW'(pa[2]);
            b_reg <= DW'(pb[0]) + DW'(pb[1]) + DW'(pb[2]);
            c_reg <= DW'(pc[0]) + DW'(pc[1]) + DW'(pc[2]);
            d_reg <= DW'(pd[0]) + DW'(pd[1]) + DW'(pd[2]);
            e_reg <= DW'(pe[0]) + DW'(pe[1]) + DW'(pe[2]);
        end
    end

    // Second multiplier bank: the six products behind det, s and t.
    logic signed [PW2-1:0] p_ac, p_bb, p_be, p_cd, p_bd, p_ae;

    cptri_mul #(.AW(DW), .BW(DW)) u_mac (
        .clk(clk), .en(en), .x(a_reg), .y(c_reg), .p(p_ac));
    cptri_mul #(.AW(DW), .BW(DW)) u_mbb (
        .clk(clk), .en(en), .x(b_reg), .y(b_reg), .p(p_bb));
    cptri_mul #(.AW(DW), .BW(DW)) u_mbe (
        .clk(clk), .en(en), .x(b_reg), .y(e_reg), .p(p_be));
    cptri_mul #(.AW(DW), .BW(DW)) u_mcd (
        .clk(clk), .en(en), .x(c_reg), .y(d_reg), .p(p_cd));
    cptri_mul #(.AW(DW), .BW(DW)) u_mbd (
        .clk(clk), .en(en), .x(b_reg), .y(d_reg), .p(p_bd));
    cptri_mul #(.AW(DW), .BW(DW)) u_mae (
        .clk(clk), .en(en), .x(a_reg), .y(e_reg), .p(p_ae));

    // The dot products wait alongside the second bank.
    logic [5*DW-1:0]      dots_d;
    logic signed [DW-1:0] da, db, dc, dd, de;

    cptri_dly #(.WIDTH(5 * DW), .DEPTH(L2)) u_dly_dots (
        .clk(clk), .en(en),
        .d({e_reg, d_reg, c_reg, b_reg, a_reg}),
        .q(dots_d));

    assign da = $signed(dots_d[0*DW +: DW]);
    assign db = $signed(dots_d[1*DW +: DW]);
    assign dc = $signed(dots_d[2*DW +: DW]);
    assign dd = $signed(dots_d[3*DW +: DW]);
    assign de = $signed(dots_d[4*DW +: DW]);

    // ------------------------------------------------------------------
    // Stage T3: det, s, t and the edge-region terms.
    // ------------------------------------------------------------------
    logic signed [XW-1:0]   det_reg, s_reg, t_reg;
    logic signed [DW-1:0]   a3_reg, c3_reg;
    logic signed [DW:0]     negd_reg, nege_reg;
    logic signed [DW+1:0]   numr_reg, denom_reg, adbe_reg;
    logic                   dneg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg   <= XW'(p_ac) - XW'(p_bb);
            s_reg     <= XW'(p_be) - XW'(p_cd);
            t_reg     <= XW'(p_bd) - XW'(p_ae);
            a3_reg    <= da;
            c3_reg    <= dc;
            negd_reg  <= -(DW + 1)'(dd);
            nege_reg  <= -(DW + 1)'(de);
            numr_reg  <= (DW + 2)'(dc) + (DW + 2)'(de) - (DW + 2)'(db) - (DW + 2)'(dd);
            denom_reg <= (DW + 2)'(da) - ((DW + 2)'(db) <<< 1) + (DW + 2)'(dc);
            adbe_reg  <= (DW + 2)'(da) + (DW + 2)'(dd) - (DW + 2)'(db) - (DW + 2)'(de);
            dneg_reg  <= dd[DW-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage T4: region selection. Lane 0 produces s', lane 1 produces t'.
    // ------------------------------------------------------------------
    logic signed [XW:0]   st_sum;
    logic                 below;
    logic signed [XW-1:0] nd_x, ne_x, a_x, c_x, nm_x, dn_x;
    logic signed [XW-1:0] num0_next, den0_next, num1_next, den1_next;
    cptri_pkg::sel_t      sel_next;

    assign st_sum = (XW + 1)'(s_reg) + (XW + 1)'(t_reg);
    assign below  = st_sum < (XW + 1)'(det_reg);
    assign nd_x   = XW'(negd_reg);
    assign ne_x   = XW'(nege_reg);
    assign a_x    = XW'(a3_reg);
    assign c_x    = XW'(c3_reg);
    assign nm_x   = XW'(numr_reg);
    assign dn_x   = XW'(denom_reg);

    always_comb
    begin
        num0_next = '0;
        den0_next = '0;
        num1_next = '0;
        den1_next = '0;
        sel_next  = '0;
        if (below)
        begin
            if (s_reg[XW-1])
            begin
                if (t_reg[XW-1] && dneg_reg)
                begin
                    // Vertex/edge region past A along E0.
                    num0_next     = nd_x;
                    den0_next     = a_x;
                    sel_next.use0 = 1'b1;
                end
                else
                begin
                    num1_next     = ne_x;
                    den1_next     = c_x;
                    sel_next.use1 = 1'b1;
                end
            end
            else if (t_reg[XW-1])
            begin
                num0_next     = nd_x;
                den0_next     = a_x;
                sel_next.use0 = 1'b1;
            end
            else
            begin
                // Interior: both parameters scale by the inverse determinant.
                num0_next     = s_reg;
                den0_next     = det_reg;
                num1_next     = t_reg;
                den1_next     = det_reg;
                sel_next.use0 = 1'b1;
                sel_next.use1 = 1'b1;
            end
        end
        else
        begin
            if (s_reg[XW-1])
            begin
                if (numr_reg > 0)
                begin
                    num0_next     = nm_x;
                    den0_next     = dn_x;
                    sel_next.use0 = 1'b1;
                    sel_next.comp = 1'b1;
                end
                else
                begin
                    num1_next     = ne_x;
                    den1_next     = c_x;
                    sel_next.use1 = 1'b1;
                end
            end
            else if (t_reg[XW-1])
            begin
                if (adbe_reg > 0)
                begin
                    num0_next     = nm_x;
                    den0_next     = dn_x;
                    sel_next.use0 = 1'b1;
                    sel_next.comp = 1'b1;
                end
                else
                begin
                    num0_next     = nd_x;
                    den0_next     = a_x;
                    sel_next.use0 = 1'b1;
                end
            end
            else
            begin
                // Opposite edge B-C.
                num0_next     = nm_x;
                den0_next     = dn_x;
                sel_next.use0 = 1'b1;
                sel_next.comp = 1'b1;
            end
        end
    end

    logic signed [XW-1:0] num0_reg, den0_reg, num1_reg, den1_reg;
    cptri_pkg::sel_t      sel_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num0_reg <= num0_next;
            den0_reg <= den0_next;
            num1_reg <= num1_next;
            den1_reg <= den1_next;
            sel_reg  <= sel_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage T5: clamp classification; a non-positive divisor on a lane in use makes it degenerate.
    // ------------------------------------------------------------------
    cptri_pkg::qclass_t cls0_next, cls1_next;
    logic               bad0, bad1;
    cptri_pkg::ctl_t    ctl_next;

    always_comb
    begin
        bad0 = (den0_reg <= 0);
        bad1 = (den1_reg <= 0);
        priority if (num0_reg <= 0)         cls0_next = cptri_pkg::QC_ZERO;
        else if (num0_reg >= den0_reg)      cls0_next = cptri_pkg::QC_ONE;
        else                                cls0_next = cptri_pkg::QC_DIV;
        priority if (num1_reg <= 0)         cls1_next = cptri_pkg::QC_ZERO;
        else if (num1_reg >= den1_reg)      cls1_next = cptri_pkg::QC_ONE;
        else                                cls1_next = cptri_pkg::QC_DIV;
        ctl_next.sel  = sel_reg;
        ctl_next.cls0 = cls0_next;
        ctl_next.cls1 = cls1_next;
        ctl_next.ok   = !(sel_reg.use0 && bad0) && !(sel_reg.use1 && bad1);
    end

    logic [NB-1:0]   n0_reg, d0_reg, n1_reg, d1_reg;
    cptri_pkg::ctl_t ctl_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n0_reg  <= num0_reg[NB-1:0];
            d0_reg  <= den0_reg[NB-1:0];
            n1_reg  <= num1_reg[NB-1:0];
            d1_reg  <= den1_reg[NB-1:0];
            ctl_reg <= ctl_next;
        end
    end

    // Two divider lanes, one quotient bit per stage.
    logic [QB-1:0]   q0, q1;
    logic [CTW-1:0]  ctl_dv;
    cptri_pkg::ctl_t ctl_d;

    cptri_div #(.NB(NB)) u_div0 (
        .clk(clk), .en(en), .num(n0_reg), .den(d0_reg), .q(q0));
    cptri_div #(.NB(NB)) u_div1 (
        .clk(clk), .en(en), .num(n1_reg), .den(d1_reg), .q(q1));
    cptri_dly #(.WIDTH(CTW), .DEPTH(QB)) u_dly_ctl (
        .clk(clk), .en(en), .d(ctl_reg), .q(ctl_dv));

    assign ctl_d = cptri_pkg::ctl_t'(ctl_dv);

    // ------------------------------------------------------------------
    // Stage T6: round the quotients (half up) and form s', t' in Q1.32.
    // ------------------------------------------------------------------
    localparam logic [QB-1:0] ONE_Q = QB'(1) << PF;

    logic [QB:0]   qr0, qr1;
    logic [QB-1:0] v0q, v1q;
    logic [QB-1:0] sq_next, tq_next;

    assign qr0 = (QB + 1)'(q0) + (QB + 1)'(1);
    assign qr1 = (QB + 1)'(q1) + (QB + 1)'(1);

    always_comb
    begin
        unique case (ctl_d.cls0)
            cptri_pkg::QC_ZERO: v0q = '0;
            cptri_pkg::QC_ONE:  v0q = ONE_Q;
            cptri_pkg::QC_DIV:  v0q = qr0[QB:1];
            default:            v0q = '0;
        endcase
        unique case (ctl_d.cls1)
            cptri_pkg::QC_ZERO: v1q = '0;
            cptri_pkg::QC_ONE:  v1q = ONE_Q;
            cptri_pkg::QC_DIV:  v1q = qr1[QB:1];
            default:            v1q = '0;
        endcase
        sq_next = ctl_d.sel.use0 ? v0q : '0;
        if (ctl_d.sel.comp)
        begin
            tq_next = ONE_Q - sq_next;
        end
        else
        begin
            tq_next = ctl_d.sel.use1 ? v1q : '0;
        end
    end

    logic [QB-1:0] sq_reg, tq_reg;
    logic          ok6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg  <= sq_next;
            tq_reg  <= tq_next;
            ok6_reg <= ctl_d.ok;
        end
    end

    // Edge vectors and vertex A wait for the final stages.
    logic [6*EW-1:0] edges_d;
    logic [3*W-1:0]  va_d;
    logic            ok_d;

    cptri_dly #(.WIDTH(6 * EW), .DEPTH(T6 - T1)) u_dly_edges (
        .clk(clk), .en(en),
        .d({e1_reg[2], e1_reg[1], e1_reg[0], e0_reg[2], e0_reg[1], e0_reg[0]}),
        .q(edges_d));
    cptri_dly #(.WIDTH(3 * W), .DEPTH(T7 - T1)) u_dly_va (
        .clk(clk), .en(en),
        .d({va_reg[2], va_reg[1], va_reg[0]}),
        .q(va_d));
    cptri_dly #(.WIDTH(1), .DEPTH(L3)) u_dly_ok (
        .clk(clk), .en(en), .d(ok6_reg), .q(ok_d));

    // Third multiplier bank: s' * E0 and t' * E1 on each axis.
    logic signed [YB-1:0]  sq_s, tq_s;
    logic signed [PW3-1:0] ps [3];
    logic signed [PW3-1:0] pt [3];

    assign sq_s = $signed({1'b0, sq_reg});
    assign tq_s = $signed({1'b0, tq_reg});

    for (genvar i = 0; i < 3; i++)
    begin : g_interp
        cptri_mul #(.AW(EW), .BW(YB)) u_ms (
            .clk(clk), .en(en), .x($signed(edges_d[i*EW +: EW])), .y(sq_s), .p(ps[i]));
        cptri_mul #(.AW(EW), .BW(YB)) u_mt (
            .clk(clk), .en(en), .x($signed(edges_d[(3+i)*EW +: EW])), .y(tq_s), .p(pt[i]));
    end

    // ------------------------------------------------------------------
    // Stage T7: sum, round half up and drop the parameter fraction.
    // ------------------------------------------------------------------
    localparam logic [PW3:0] HALF = (PW3 + 1)'(1) << (PF - 1);

    logic signed [RW-1:0] rnd_reg [3];
    logic                 ok7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rnd_reg[i] <= RW'(((PW3 + 1)'(ps[i]) + (PW3 + 1)'(pt[i]) + HALF) >> PF);
            end
            ok7_reg <= ok_d;
        end
    end

    // ------------------------------------------------------------------
    // Stage T8 (output register): add vertex A and saturate to COORD_WIDTH, or pass A through if degenerate.
    // ------------------------------------------------------------------
    logic signed [RW:0]  sum8 [3];
    logic [W-1:0]        res_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum8[i] = (RW + 1)'(rnd_reg[i]) + (RW + 1)'($signed(va_d[i*W +: W]));
            if (!ok7_reg)
            begin
                res_next[i] = va_d[i*W +: W];
            end
            else if (sum8[i][RW:W-1] == '0 || sum8[i][RW:W-1] == '1)
            begin
                res_next[i] = sum8[i][W-1:0];
            end
            else
            begin
                res_next[i] = {sum8[i][RW], {(W - 1){~sum8[i][RW]}}};
            end
        end
    end

    logic [W-1:0] res_reg [3];
    logic         deg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                res_reg[i] <= res_next[i];
            end
            deg_reg <= !ok7_reg;
        end
    end

    assign m_tdata = OUT_DW'({res_reg[2], res_reg[1], res_reg[0]});
    assign m_tuser = deg_reg;

endmodule

// File: hdl/cptri_chk.sv
// Port-level checker for the closest-point-on-triangle pipeline, with its bind.
module cptri_chk #(
    parameter int COORD_WIDTH = 32,
    localparam int OUT_DW = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_DW-1:0] m_tdata,
    input logic              m_tuser
);

    // A held result stays put until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output transaction changed while stalled");

    // The input side is open exactly when the output register can move.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output drain");

    // A new result can only appear right after the pipeline advanced.
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tready))
        else $error("output valid rose while pipeline was frozen");

    // A result only leaves when it was taken.
    a_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("output transaction dropped without acceptance");

endmodule

bind closest_point_on_triangle_core cptri_chk #(.COORD_WIDTH(COORD_WIDTH)) u_cptri_chk (.*);

// File: tb/tb_closest_point_on_triangle_core.sv
// Self-checking testbench for the closest-point-on-triangle pipeline.
module tb_closest_point_on_triangle_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PFRAC     = cptri_pkg::PFRAC;
    localparam int CW        = 32;
    localparam int IN_DW     = 12 * CW;
    localparam int OUT_DW    = 3 * CW;
    localparam int N_RANDOM  = 1400;
    localparam int PAUSE_AT  = 200;    // sender drains the pipe before this item
    localparam int QUIET_LO  = 500;    // no idling on either side in this item window
    localparam int QUIET_HI  = 800;
    localparam int ONE_Q16   = 65536;
    localparam int TAIL_CYC  = 150;    // comfortably above the pipeline latency

    // Wide signed intermediate for the dot products and determinant terms.
    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic          degenerate;
    } closest_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_DW-1:0]  s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_DW-1:0] m_tdata;
    logic              m_tuser;

    logic [IN_DW-1:0]  pending_items[$];   // stimulus not yet offered to the block
    closest_t          closest_q[$];       // predicted results, oldest first
    int                launched = 0;
    int                checked = 0;
    int                degen_seen = 0;
    int                errors = 0;
    bit                pause_done = 1'b0;
    bit                quiet;

    closest_point_on_triangle_core #(.COORD_WIDTH(CW)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Clamped parameter quotient in unsigned Q1.32; returns 0 when the divisor is not positive.
    function automatic bit clamp_quot(input wide_t num, input wide_t den,
                                      output logic [PFRAC:0] q);
        wide_t full;
        q = '0;
        if (den <= 0)
            return 1'b0;
        if (num <= 0)
            q = '0;
        else if (num >= den)
            q = {1'b1, {PFRAC{1'b0}}};
        else
        begin
            // Round half up: (2*num*2^32 + den) / (2*den).
            full = ((num <<< (PFRAC + 1)) + den) / (den <<< 1);
            q = full[PFRAC:0];
        end
        return 1'b1;
    endfunction

    // Computes the expected closest point for one packed input transaction.
    function automatic closest_t predict_closest(input logic [IN_DW-1:0] item);
        logic signed [CW-1:0] word;
        wide_t                pt[3], va[3], e0[3], e1[3], v0[3];
        wide_t                a, b, c, d, e, det, s, t, denom, numr, acc, r, sw, tw;
        wide_t                hi, lo;
        logic [PFRAC:0]       sq, tq, one;
        bit                   ok;
        closest_t             res;
        sq  = '0;
        tq  = '0;
        one = {1'b1, {PFRAC{1'b0}}};
        hi  = (wide_t'(1) <<< (CW - 1)) - 1;
        lo  = -hi - 1;
        for (int i = 0; i < 3; i++)
        begin
            word  = item[CW*i +: CW];       pt[i] = word;
            word  = item[CW*(3+i) +: CW];   va[i] = word;
            word  = item[CW*(6+i) +: CW];   e0[i] = word;
            word  = item[CW*(9+i) +: CW];   e1[i] = word;
            e0[i] = e0[i] - va[i];
            e1[i] = e1[i] - va[i];
            v0[i] = va[i] - pt[i];
        end
        a = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
        b = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
        c = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
        d = e0[0]*v0[0] + e0[1]*v0[1] + e0[2]*v0[2];
        e = e1[0]*v0[0] + e1[1]*v0[1] + e1[2]*v0[2];
        det   = a*c - b*b;
        s     = b*e - c*d;
        t     = b*d - a*e;
        denom = a - (b <<< 1) + c;
        numr  = c + e - b - d;

        // Seven-region classification: below the far edge first, then beyond it.
        if (s + t < det)
        begin
            if (s < 0)
            begin
                if (t < 0 && d < 0)
                    ok = clamp_quot(-d, a, sq);
                else
                    ok = clamp_quot(-e, c, tq);
            end
            else if (t < 0)
                ok = clamp_quot(-d, a, sq);
            else
                ok = clamp_quot(s, det, sq) && clamp_quot(t, det, tq);
        end
        else
        begin
            if (s < 0)
            begin
                if (c + e > b + d)
                begin
                    ok = clamp_quot(numr, denom, sq);
                    tq = one - sq;
                end
                else
                    ok = clamp_quot(-e, c, tq);
            end
            else if (t < 0)
            begin
                if (a + d > b + e)
                begin
                    ok = clamp_quot(numr, denom, sq);
                    tq = one - sq;
                end
                else
                    ok = clamp_quot(-d, a, sq);
            end
            else
            begin
                ok = clamp_quot(numr, denom, sq);
                tq = one - sq;
            end
        end

        sw = {{(256-PFRAC-1){1'b0}}, sq};
        tw = {{(256-PFRAC-1){1'b0}}, tq};
        for (int i = 0; i < 3; i++)
        begin
            r = va[i];
            if (ok)
            begin
                acc = (sw*e0[i] + tw*e1[i] + (wide_t'(1) <<< (PFRAC - 1))) >>> PFRAC;
                r = r + acc;
                if (r > hi) r = hi;
                if (r < lo) r = lo;
            end
            case (i)
                0: res.x = r[CW-1:0];
                1: res.y = r[CW-1:0];
                default: res.z = r[CW-1:0];
            endcase
        end
        res.degenerate = !ok;
        return res;
    endfunction

    function automatic logic [IN_DW-1:0] pack_item(
        input int px, input int py, input int pz,
        input int ax, input int ay, input int az,
        input int bx, input int by, input int bz,
        input int cx, input int cy, input int cz);
        return {cz, cy, cx, bz, by, bx, az, ay, ax, pz, py, px};
    endfunction

    // Small signed value in about +/- 2^(bits-1).
    function automatic int small_coord(input int bits);
        return int'($urandom_range((1 << bits) - 1)) - (1 << (bits - 1));
    endfunction

    // Random item: mostly well-formed triangles at moderate scale, some full-range
    // noise, and some collapsed triangles to hit the degenerate paths.
    function automatic logic [IN_DW-1:0] random_item();
        int sel, sc, k;
        int v[12];
        sel = $urandom_range(99);
        sc  = $urandom_range(24, 8);
        for (int i = 0; i < 12; i++)
            v[i] = small_coord(sc);
        if (sel < 25)
        begin
            for (int i = 0; i < 12; i++)
                v[i] = $urandom;
        end
        else if (sel < 33)
        begin
            for (int i = 0; i < 3; i++)
                v[6+i] = v[3+i];                  // B coincides with A
        end
        else if (sel < 38)
        begin
            for (int i = 0; i < 3; i++)
                v[9+i] = v[3+i];                  // C coincides with A
        end
        else if (sel < 45)
        begin
            k = small_coord(3);                   // C on the line through A and B
            for (int i = 0; i < 3; i++)
            begin
                v[6+i] = v[3+i] + small_coord(8);
                v[9+i] = v[3+i] + k * (v[6+i] - v[3+i]);
            end
        end
        return pack_item(v[0], v[1], v[2], v[3], v[4], v[5],
                         v[6], v[7], v[8], v[9], v[10], v[11]);
    endfunction

    // Stimulus: directed corner cases, then the random stream.
    initial
    begin
        int u, mx, mn;
        u  = ONE_Q16;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        // Everything zero: fully degenerate.
        pending_items.push_back(pack_item(0,0,0, 0,0,0, 0,0,0, 0,0,0));
        // Unit right triangle in the xy plane, one query per region.
        pending_items.push_back(pack_item(u/4,u/4,u,   0,0,0, u,0,0, 0,u,0));  // interior
        pending_items.push_back(pack_item(-u,-u,0,     0,0,0, u,0,0, 0,u,0));  // vertex A
        pending_items.push_back(pack_item(u/2,-u,0,    0,0,0, u,0,0, 0,u,0));  // edge AB
        pending_items.push_back(pack_item(-u,u/2,0,    0,0,0, u,0,0, 0,u,0));  // edge AC
        pending_items.push_back(pack_item(u,u,-u,      0,0,0, u,0,0, 0,u,0));  // edge BC
        pending_items.push_back(pack_item(2*u,-u,0,    0,0,0, u,0,0, 0,u,0));  // beyond B
        pending_items.push_back(pack_item(-u,2*u,0,    0,0,0, u,0,0, 0,u,0));  // beyond C
        pending_items.push_back(pack_item(3*u,u/5,0,   0,0,0, u,0,0, 0,u,0));
        pending_items.push_back(pack_item(u/5,3*u,0,   0,0,0, u,0,0, 0,u,0));
        pending_items.push_back(pack_item(-u,-u/2,0,   0,0,0, u,0,0, 0,u,0));  // s<0,t<0,d>=0
        pending_items.push_back(pack_item(u/3,u/3,0,   0,0,0, u,0,0, 0,u,0));  // on the plane
        // Collinear and collapsed triangles.
        pending_items.push_back(pack_item(u,u,0,       0,0,0, u,0,0, 2*u,0,0));
        pending_items.push_back(pack_item(-u,5,7,      0,0,0, u,0,0, 2*u,0,0));
        pending_items.push_back(pack_item(9,9,9,       u,u,u, u,u,u, 0,u,0));
        pending_items.push_back(pack_item(9,9,9,       u,u,u, 0,u,0, u,u,u));
        // Full-scale coordinates, driving the saturation logic.
        pending_items.push_back(pack_item(mx,mx,mx, mx,mx,mx, mx,mx,mx, mx,mx,mx));
        pending_items.push_back(pack_item(mn,mn,mn, mn,mn,mn, mn,mn,mn, mn,mn,mn));
        pending_items.push_back(pack_item(0,0,0,    mn,mn,mn, mx,mn,mn, mn,mx,mn));
        pending_items.push_back(pack_item(mx,mx,mx, mn,mn,mn, mx,mn,mx, mn,mx,mx));
        pending_items.push_back(pack_item(mn,mx,0,  mx,mx,mx, mn,mx,mn, mx,mn,mn));
        pending_items.push_back(pack_item(mx,mn,mx, 0,0,0,    mx,mx,0,  mn,mx,mx));
        for (int n = 0; n < N_RANDOM; n++)
            pending_items.push_back(random_item());

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    assign quiet = (launched >= QUIET_LO) && (launched < QUIET_HI);

    // Driver: records each accepted transaction and offers the next pending item.
    always @(posedge clk)
    begin
        bit go;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                closest_q.push_back(predict_closest(s_tdata));
            // Drain the whole pipe once before item PAUSE_AT is offered.
            if (launched == PAUSE_AT && !pause_done && !s_tvalid && closest_q.size() == 0)
                pause_done = 1'b1;
            if (!s_tvalid || s_tready)
            begin
                go = pending_items.size() > 0
                     && (quiet || $urandom_range(99) >= 12)
                     && !(launched == PAUSE_AT && !pause_done);
                if (go)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_items.pop_front();
                    launched++;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure and in-order comparison against predictions.
    always @(posedge clk)
    begin
        closest_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (closest_q.size() == 0)
                begin
                    $error("result transaction with no prediction pending");
                    errors++;
                end
                else
                begin
                    want = closest_q.pop_front();
                    checked++;
                    if (want.degenerate)
                        degen_seen++;
                    if (m_tdata[CW-1:0] !== want.x)
                    begin
                        $error("closest_x: expected %h, got %h", want.x, m_tdata[CW-1:0]);
                        errors++;
                    end
                    if (m_tdata[2*CW-1:CW] !== want.y)
                    begin
                        $error("closest_y: expected %h, got %h", want.y, m_tdata[2*CW-1:CW]);
                        errors++;
                    end
                    if (m_tdata[3*CW-1:2*CW] !== want.z)
                    begin
                        $error("closest_z: expected %h, got %h", want.z,
                               m_tdata[3*CW-1:2*CW]);
                        errors++;
                    end
                    if (m_tuser !== want.degenerate)
                    begin
                        $error("degenerate: expected %b, got %b", want.degenerate, m_tuser);
                        errors++;
                    end
                end
            end
            m_tready <= quiet || ($urandom_range(99) >= 12);
        end
    end

    // End of run: all stimulus accepted, all predictions compared, then a quiet tail.
    initial
    begin
        @(posedge rst_n);
        while (pending_items.size() != 0 || s_tvalid || closest_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);
        if (closest_q.size() != 0)
        begin
            $error("%0d predicted results never arrived", closest_q.size());
            errors++;
        end
        $display("Checked %0d closest-point results (%0d degenerate) over directed regions,",
                 checked, degen_seen);
        $display("full-scale saturation and random triangles with stalls on both sides.");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
